// ===== rtl/ftprlp_pkg.sv =====
package ftprlp_pkg;

	// Default reply capacity in bytes; a completed reply is at most one less.
	localparam int REPLY_CAPACITY_DEF = 1024;

	localparam int CODE_W   = 10;
	localparam int LENGTH_W = 10;
	localparam int POS_W    = 3;

	// Line position saturates here: four characters plus the CR seen.
	localparam logic [POS_W-1:0] POS_SAT = 3'd5;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_FIVE  = 8'h35;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Class of the fourth character of a line.
	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_SPACE = 2'd1,
		CLS_DASH  = 2'd2
	} char_class_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} char_item_t;

	typedef struct packed {
		logic                reply_done;
		logic [CODE_W-1:0]   reply_code;
		logic [LENGTH_W-1:0] reply_size;
		logic                overflow;
	} reply_item_t;

endpackage

// ===== rtl/ftprlp_chan_if.sv =====
interface ftprlp_chan_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/ftp_reply_line_parser.sv =====
// Channel   Modport  Payload                                              Role
// chars     sink     data_byte[7:0], restart                              control bytes
// replies   source   reply_done, reply_code[9:0], reply_size[9:0],        one result per byte
//                    overflow
//
// Every accepted byte gives exactly one result transaction: the byte is held in the input register,
// then its result is registered in the result register and offered from there.
// One byte per clock is sustained while replies.ready stays high: an input register and a result register each hold
// one transaction, and the parser state updates in the same cycle a byte moves between them.
// A stalled result register still lets one more byte enter the input register.
// arst_n clears both valid bits and the parser state to its idle values.
module ftp_reply_line_parser #(
	parameter int REPLY_CAPACITY = ftprlp_pkg::REPLY_CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	ftprlp_chan_if.sink   chars,
	ftprlp_chan_if.source replies
);

	// Byte counter holds at most REPLY_CAPACITY - 1.
	localparam int CW = $clog2(REPLY_CAPACITY);
	localparam logic [CW:0] CAP = (CW+1)'(REPLY_CAPACITY);

	localparam int CODE_W = ftprlp_pkg::CODE_W;
	localparam int POS_W  = ftprlp_pkg::POS_W;

	// Handshake and pipeline registers.
	logic                    vld_s1;
	ftprlp_pkg::char_item_t  item_s1;
	logic                    vld_s2;
	ftprlp_pkg::reply_item_t res_s2;
	logic                    advance;
	logic                    take;

	// Parser state.
	logic                    prev_cr_q;
	logic [POS_W-1:0]        pos_q;
	logic [CODE_W-1:0]       code_q;
	logic                    digits_ok_q;
	ftprlp_pkg::char_class_t cls_q;
	logic                    first_line_q;
	logic [CODE_W-1:0]       ml_code_q;
	logic [CW-1:0]           count_q;
	logic                    ovf_q;

	// State as seen by the byte, after an optional restart.
	logic                    cur_prev_cr;
	logic [POS_W-1:0]        cur_pos;
	logic [CODE_W-1:0]       cur_code;
	logic                    cur_digits_ok;
	ftprlp_pkg::char_class_t cur_cls;
	logic                    cur_first_line;
	logic [CODE_W-1:0]       cur_ml_code;
	logic [CW-1:0]           cur_count;
	logic                    cur_ovf;

	logic                    nxt_prev_cr;
	logic [POS_W-1:0]        nxt_pos;
	logic [CODE_W-1:0]       nxt_code;
	logic                    nxt_digits_ok;
	ftprlp_pkg::char_class_t nxt_cls;
	logic                    nxt_first_line;
	logic [CODE_W-1:0]       nxt_ml_code;
	logic [CW-1:0]           nxt_count;
	logic                    nxt_ovf;

	ftprlp_pkg::reply_item_t res;
	logic [CW:0]             count_inc;
	logic [CW+9:0]           length_ext;
	logic [7:0]              b;
	logic [3:0]              digit;
	logic                    is_digit;
	logic                    line_valid;
	logic [CODE_W-1:0]       ml_code_line;
	logic                    done;

	// The result register frees up when empty or when its transaction is taken this cycle.
	assign advance       = !vld_s2 || replies.ready;
	assign take          = vld_s1 && advance;
	assign chars.ready   = !vld_s1 || advance;
	assign replies.valid = vld_s2;
	assign replies.payload = res_s2;

	assign b          = item_s1.data_byte;
	assign digit      = b[3:0];
	assign is_digit   = (b >= ftprlp_pkg::CHAR_ZERO) && (b <= ftprlp_pkg::CHAR_NINE);
	assign count_inc  = (CW+1)'(cur_count) + (CW+1)'(1);
	assign length_ext = {10'd0, count_inc[CW-1:0]};

	// A restart behaves as if the byte arrived right after reset.
	always_comb begin
		if (item_s1.restart) begin
			cur_prev_cr    = 1'b0;
			cur_pos        = '0;
			cur_code       = '0;
			cur_digits_ok  = 1'b1;
			cur_cls        = ftprlp_pkg::CLS_OTHER;
			cur_first_line = 1'b1;
			cur_ml_code    = '0;
			cur_count      = '0;
			cur_ovf        = 1'b0;
		end else begin
			cur_prev_cr    = prev_cr_q;
			cur_pos        = pos_q;
			cur_code       = code_q;
			cur_digits_ok  = digits_ok_q;
			cur_cls        = cls_q;
			cur_first_line = first_line_q;
			cur_ml_code    = ml_code_q;
			cur_count      = count_q;
			cur_ovf        = ovf_q;
		end
	end

	// One byte of parsing. A line ends on CR then LF; the first three characters build
	// the code and the fourth is classified.
	always_comb begin
		nxt_prev_cr    = cur_prev_cr;
		nxt_pos        = cur_pos;
		nxt_code       = cur_code;
		nxt_digits_ok  = cur_digits_ok;
		nxt_cls        = cur_cls;
		nxt_first_line = cur_first_line;
		nxt_ml_code    = cur_ml_code;
		nxt_count      = cur_count;
		nxt_ovf        = cur_ovf;
		line_valid     = cur_pos >= ftprlp_pkg::POS_SAT && cur_digits_ok;
		ml_code_line   = cur_ml_code;
		done           = 1'b0;
		res            = '0;

		if (!cur_ovf) begin
			if (count_inc >= CAP) begin
				// The byte that would fill the capacity is dropped and the reply abandoned.
				nxt_ovf        = 1'b1;
				nxt_prev_cr    = 1'b0;
				nxt_pos        = '0;
				nxt_code       = '0;
				nxt_digits_ok  = 1'b1;
				nxt_cls        = ftprlp_pkg::CLS_OTHER;
				nxt_first_line = 1'b1;
				nxt_ml_code    = '0;
				nxt_count      = '0;
			end else begin
				nxt_count = count_inc[CW-1:0];
				if (cur_prev_cr && b == ftprlp_pkg::CHAR_LF) begin
					if (line_valid && cur_first_line && cur_cls == ftprlp_pkg::CLS_DASH) begin
						ml_code_line = cur_code;
					end
					done = line_valid && cur_cls == ftprlp_pkg::CLS_SPACE &&
						(ml_code_line == '0 || cur_code == ml_code_line);
					nxt_prev_cr   = 1'b0;
					nxt_pos       = '0;
					nxt_code      = '0;
					nxt_digits_ok = 1'b1;
					nxt_cls       = ftprlp_pkg::CLS_OTHER;
					if (done) begin
						nxt_first_line = 1'b1;
						nxt_ml_code    = '0;
						nxt_count      = '0;
						res.reply_done = 1'b1;
						res.reply_code = cur_code;
						res.reply_size = length_ext[9:0];
					end else begin
						nxt_first_line = 1'b0;
						nxt_ml_code    = ml_code_line;
					end
				end else begin
					unique case (cur_pos)
						3'd0: begin
							if (b >= ftprlp_pkg::CHAR_ONE && b <= ftprlp_pkg::CHAR_FIVE) begin
								nxt_code = CODE_W'(digit) * CODE_W'(100);
							end else begin
								nxt_digits_ok = 1'b0;
							end
						end
						3'd1: begin
							if (is_digit) begin
								nxt_code = cur_code + CODE_W'(digit) * CODE_W'(10);
							end else begin
								nxt_digits_ok = 1'b0;
							end
						end
						3'd2: begin
							if (is_digit) begin
								nxt_code = cur_code + CODE_W'(digit);
							end else begin
								nxt_digits_ok = 1'b0;
							end
						end
						3'd3: begin
							if (b == ftprlp_pkg::CHAR_SPACE) begin
								nxt_cls = ftprlp_pkg::CLS_SPACE;
							end else if (b == ftprlp_pkg::CHAR_DASH) begin
								nxt_cls = ftprlp_pkg::CLS_DASH;
							end else begin
								nxt_cls = ftprlp_pkg::CLS_OTHER;
							end
						end
						default: begin
						end
					endcase
					if (cur_pos < ftprlp_pkg::POS_SAT) begin
						nxt_pos = cur_pos + POS_W'(1);
					end
					nxt_prev_cr = (b == ftprlp_pkg::CHAR_CR);
				end
			end
		end
		res.overflow = nxt_ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (chars.ready) begin
				vld_s1 <= chars.valid;
			end
			if (advance) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1 <= chars.payload;
		end
		if (take) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cr_q    <= 1'b0;
			pos_q        <= '0;
			code_q       <= '0;
			digits_ok_q  <= 1'b1;
			cls_q        <= ftprlp_pkg::CLS_OTHER;
			first_line_q <= 1'b1;
			ml_code_q    <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
		end else if (take) begin
			prev_cr_q    <= nxt_prev_cr;
			pos_q        <= nxt_pos;
			code_q       <= nxt_code;
			digits_ok_q  <= nxt_digits_ok;
			cls_q        <= nxt_cls;
			first_line_q <= nxt_first_line;
			ml_code_q    <= nxt_ml_code;
			count_q      <= nxt_count;
			ovf_q        <= nxt_ovf;
		end
	end

	// A completed reply carries a code from 100 to 599.
	a_done_code: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.reply_done |-> res_s2.reply_code >= 10'd100 &&
			res_s2.reply_code <= 10'd599)
		else $error("completed reply with code out of range");

	// The shortest complete reply is three digits, a space and CRLF.
	a_done_length: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.reply_done |-> res_s2.reply_size >= 10'd6 ||
			REPLY_CAPACITY > 1024)
		else $error("completed reply shorter than one line");

	// Without completion the code and length fields stay zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !res_s2.reply_done |-> res_s2.reply_code == '0 &&
			res_s2.reply_size == '0)
		else $error("code or length given without completion");

	// Overflow holds until a restart.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !(take && item_s1.restart) |=> ovf_q)
		else $error("overflow cleared without restart");

	// The result reported for a byte matches the stored overflow flag.
	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_s2.overflow == ovf_q)
		else $error("result overflow differs from parser state");

	// Input is refused only while both registers are full and the output is stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> vld_s1 && vld_s2 && !replies.ready)
		else $error("input stalled with room in the pipeline");

endmodule
